// ===== sv/bisection_table_interpolator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the table interpolator
// ----------------------------------------------------------------------------
`ifndef BISECTION_TABLE_INTERPOLATOR_MACROS_SVH
`define BISECTION_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define BTI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bti: implication check failed");

// next-cycle implication
`define BTI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bti: next-cycle check failed");

`endif

// ===== sv/bti_pkg.sv =====
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the bisection table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

	localparam int unsigned RCV_W = 7;
	localparam int unsigned MAG_W = 33;
	localparam int unsigned PRD_W = 66;
	localparam int unsigned QUO_W = 35;
	localparam int unsigned SUM_W = 37;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic CFG_ENTRY_COUNT = 1'b0;
	localparam logic CFG_USE_DEPTH   = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOR = 1'b1;

	typedef struct packed {
		logic signed [31:0] coord;
		logic signed [31:0] value;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
		logic [MAG_W-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} md_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > SUM_W'(signed'(32'sh7fffffff)))
			r = 32'sh7fffffff;
		else if (v < SUM_W'(signed'(-32'sh80000000)))
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== sv/bti_in_if.sv =====
// ----------------------------------------------------------------------------
// bti_in_if
// Input channel: table writes and queries.
// ----------------------------------------------------------------------------
interface bti_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [5:0]         entry_index;
	logic signed [31:0] entry_coord;
	logic signed [31:0] entry_value;
	logic signed [31:0] radius_value;
	logic signed [31:0] depth_value;
	logic               first_zone;

	modport source (output valid, kind, entry_index, entry_coord, entry_value,
		radius_value, depth_value, first_zone, input ready);
	modport sink (input valid, kind, entry_index, entry_coord, entry_value,
		radius_value, depth_value, first_zone, output ready);
endinterface

// ===== sv/bti_out_if.sv =====
// ----------------------------------------------------------------------------
// bti_out_if
// Output channel: query results.
// ----------------------------------------------------------------------------
interface bti_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               status;

	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

// ===== sv/bti_table_ram.sv =====
// ----------------------------------------------------------------------------
// bti_table_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bti_table_ram
	import bti_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/bti_muldiv.sv =====
// ----------------------------------------------------------------------------
// bti_muldiv
// floor(a*b/d): shift-add multiply, then restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module bti_muldiv
	import bti_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;
	localparam logic [1:0] P_DONE = 2'd3;

	logic [1:0]       phase_q;
	logic [6:0]       cnt_q;
	logic [PRD_W-1:0] mcand_q;
	logic [MAG_W-1:0] mplier_q;
	logic [PRD_W-1:0] prod_q;
	logic [MAG_W-1:0] dvsr_q;
	logic [MAG_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic             ovf_q;

	logic [MAG_W:0] rem_sh;
	logic           fits;

	assign rem_sh = {rem_q, prod_q[PRD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				P_IDLE: begin
					if (req.start) begin
						phase_q <= P_MUL;
						cnt_q   <= '0;
					end
				end
				P_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(MAG_W - 1)) begin
						phase_q <= P_DIV;
						cnt_q   <= '0;
					end
				end
				P_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(PRD_W - 1))
						phase_q <= P_DONE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				mcand_q  <= {{(PRD_W-MAG_W){1'b0}}, req.a};
				mplier_q <= req.b;
				dvsr_q   <= req.d;
				prod_q   <= '0;
				rem_q    <= '0;
				quo_q    <= '0;
				ovf_q    <= 1'b0;
			end
			P_MUL: begin
				if (mplier_q[0])
					prod_q <= prod_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			P_DIV: begin
				rem_q  <= fits ? MAG_W'(rem_sh - {1'b0, dvsr_q}) : rem_sh[MAG_W-1:0];
				quo_q  <= {quo_q[QUO_W-2:0], fits};
				ovf_q  <= ovf_q | quo_q[QUO_W-1];
				prod_q <= prod_q << 1;
			end
			default: ;
		endcase
	end

	assign rsp.done = phase_q == P_DONE;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== sv/bisection_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// bisection_table_interpolator
// Q16.16 piecewise-linear table lookup with bisection search.
// ----------------------------------------------------------------------------
// Input channel in_ch carries write items (kind 0), which store one entry and
// give no result, and queries (kind 1), which give one result on out_ch. The
// config port sets entry_count (index 0) and use_depth (index 1); the user
// must write them only while the block is idle, which the block does not enforce.
// A query is taken only when the block is idle; one query is worked at a
// time. First-zone and below-range results go from S_CHK0 to S_FIN, while
// above-range ones pass through S_CHKN as well. An interpolating query does k
// bisection reads, k = ceil(log2(entry_count - 1)), then a shift-add multiply
// and a restoring divide in the arithmetic unit; a zero-width interval skips
// the arithmetic unit. The next item is taken in the cycle after the result
// is loaded.
// Results sit in an output register; the next item is taken while a result
// waits, and a finished query holds until the register frees up.
// Reset clears control state and the config registers (entry_count 2,
// use_depth 0); table contents are undefined until written.
// ----------------------------------------------------------------------------
`include "bisection_table_interpolator_macros.svh"

module bisection_table_interpolator
	import bti_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	bti_in_if.sink     in_ch,
	bti_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK0  = 3'd1;
	localparam logic [2:0] S_CHKN  = 3'd2;
	localparam logic [2:0] S_BIS   = 3'd3;
	localparam logic [2:0] S_ARITH = 3'd4;
	localparam logic [2:0] S_WAIT  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]         state_q;
	logic [6:0]         entry_count_q;
	logic               use_depth_q;
	logic signed [31:0] x_q;
	logic               fz_q;
	logic [AW-1:0]      lo_idx_q, hi_idx_q, mid_q;
	entry_t             lo_e_q, hi_e_q;
	logic               neg_q;
	logic signed [31:0] res_q;
	logic               st_q;
	logic               ov_q;
	logic signed [31:0] ov_val_q;
	logic               ov_st_q;

	logic [AW-1:0] wrap_lut [64];
	logic [AW-1:0] nm1;
	logic [AW-1:0] blo, bhi, nmid;
	logic          last;
	logic [AW-1:0] raddr;
	entry_t        rdata;
	entry_t        wdata;
	logic          in_xfer, ram_we, go_le;
	logic          out_free;
	md_req_t       md_req;
	md_rsp_t       md_rsp;

	logic signed [32:0]      dd, dx, dv;
	logic signed [SUM_W-1:0] vlo_ext, q_ext;

	for (genvar g = 0; g < 64; g++) begin : g_wrap
		assign wrap_lut[g] = AW'(g % TABLE_DEPTH);
	end

	always_comb begin
		if (int'(entry_count_q) > TABLE_DEPTH)
			nm1 = AW'(TABLE_DEPTH - 1);
		else if (entry_count_q < 7'd2)
			nm1 = AW'(1);
		else
			nm1 = AW'(entry_count_q - 7'd1);
	end

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign ram_we   = in_xfer && in_ch.kind == KIND_WRITE;
	assign in_ch.ready = state_q == S_IDLE;
	assign wdata.coord = in_ch.entry_coord;
	assign wdata.value = in_ch.entry_value;
	assign go_le    = x_q <= rdata.coord;
	assign out_free = !ov_q || out_ch.ready;

	always_comb begin
		blo = lo_idx_q;
		bhi = hi_idx_q;
		if (state_q == S_CHKN) begin
			blo = '0;
			bhi = nm1;
		end else if (go_le) begin
			bhi = mid_q;
		end else begin
			blo = mid_q;
		end
		nmid = AW'(({1'b0, blo} + {1'b0, bhi}) >> 1);
		last = ({1'b0, blo} + 1'b1) == {1'b0, bhi};
	end

	always_comb begin
		case (state_q)
			S_CHK0:  raddr = nm1;
			S_CHKN:  raddr = nmid;
			S_BIS:   raddr = nmid;
			default: raddr = '0;
		endcase
	end

	bti_table_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wrap_lut[in_ch.entry_index]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign dd = 33'(hi_e_q.coord) - 33'(lo_e_q.coord);
	assign dx = 33'(x_q) - 33'(lo_e_q.coord);
	assign dv = 33'(hi_e_q.value) - 33'(lo_e_q.value);

	assign md_req.start = state_q == S_ARITH && dd != '0;
	assign md_req.a     = dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
	assign md_req.b     = dv[32] ? MAG_W'(-dv) : MAG_W'(dv);
	assign md_req.d     = dd[32] ? MAG_W'(-dd) : MAG_W'(dd);

	bti_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign vlo_ext = SUM_W'(lo_e_q.value);
	assign q_ext   = signed'({2'b00, md_rsp.quo});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= 7'd2;
			use_depth_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENTRY_COUNT: entry_count_q <= cfg_data;
				CFG_USE_DEPTH:   use_depth_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				ov_q <= 1'b1;
			else if (ov_q && out_ch.ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer && in_ch.kind == KIND_QUERY)
						state_q <= S_CHK0;
				end
				S_CHK0: begin
					if (fz_q || x_q < rdata.coord)
						state_q <= S_FIN;
					else
						state_q <= S_CHKN;
				end
				S_CHKN: begin
					if (x_q >= rdata.coord)
						state_q <= S_FIN;
					else if (last)
						state_q <= S_ARITH;
					else
						state_q <= S_BIS;
				end
				S_BIS: begin
					if (last)
						state_q <= S_ARITH;
				end
				S_ARITH: begin
					state_q <= (dd == '0) ? S_FIN : S_WAIT;
				end
				S_WAIT: begin
					if (md_rsp.done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q  <= use_depth_q ? in_ch.depth_value : in_ch.radius_value;
				fz_q <= in_ch.first_zone;
			end
			S_CHK0: begin
				lo_e_q <= rdata;
				res_q  <= fz_q ? rdata.value : 32'sd0;
				st_q   <= fz_q ? STATUS_OK : STATUS_OOR;
			end
			S_CHKN: begin
				hi_e_q   <= rdata;
				lo_idx_q <= blo;
				hi_idx_q <= bhi;
				mid_q    <= nmid;
				res_q    <= 32'sd0;
				st_q     <= STATUS_OOR;
			end
			S_BIS: begin
				if (go_le)
					hi_e_q <= rdata;
				else
					lo_e_q <= rdata;
				lo_idx_q <= blo;
				hi_idx_q <= bhi;
				mid_q    <= nmid;
			end
			S_ARITH: begin
				neg_q <= (dx[32] != dv[32]) != dd[32];
				res_q <= lo_e_q.value;
				st_q  <= STATUS_OK;
			end
			S_WAIT: begin
				if (md_rsp.done) begin
					if (md_rsp.ovf)
						res_q <= neg_q ? -32'sh80000000 : 32'sh7fffffff;
					else
						res_q <= sat32(neg_q ? vlo_ext - q_ext : vlo_ext + q_ext);
				end
			end
			S_FIN: begin
				if (out_free) begin
					ov_val_q <= res_q;
					ov_st_q  <= st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.result_value = ov_val_q;
	assign out_ch.status       = ov_st_q;

	`BTI_ASSERT_IMP(a_ready_idle, in_ch.ready, state_q == S_IDLE)
	`BTI_ASSERT_IMP(a_done_in_wait, md_rsp.done, state_q == S_WAIT)
	`BTI_ASSERT_NXT(a_fin_loads, state_q == S_FIN && out_free, out_ch.valid && state_q == S_IDLE)
	`BTI_ASSERT_IMP(a_bis_order, state_q == S_BIS, lo_idx_q < hi_idx_q)

endmodule
